>>> hdl/tme_pkg.sv
// Shared types and codes for the tape machine executor.
// No dependencies; imported by every module of the block except tme_ram.
`default_nettype none
package tme_pkg;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_LEFT  = 3'd2,
    MODE_RIGHT = 3'd3,
    MODE_READ  = 3'd4,
    MODE_WRITE = 3'd5,
    MODE_JZ    = 3'd6,
    MODE_JNZ   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2
  } fault_t;

  // Item as it travels from pointer stage to execute stage.
  typedef struct packed {
    mode_t       mode;
    logic [15:0] amount;
    logic [15:0] cur;       // masked current address
    logic [15:0] next_seq;  // masked current address plus one
    logic [15:0] target;    // masked jump target
    logic [7:0]  data;
    logic        active;    // not halted and no fault
    fault_t      fault;
  } item_t;

  // Write request towards the tape memory.
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } wr_t;

endpackage
`default_nettype wire

>>> hdl/tape_machine_executor_core.sv
// Top level of the tape machine executor: pointer stage, execute stage, tape RAM.
// Depends on tme_pkg, tme_ram, tme_ctrl and tme_exec.
//
// The block executes one pre-decoded run-length instruction per item and
// returns exactly one result item for each. After reset it sweeps the tape to
// zero, one cell a cycle, and in_stall stays high until the sweep ends and
// the first item can be taken. After that it takes one item every cycle
// while the output is not stalled: the pointer stage moves the cell pointer
// and starts the tape read in the cycle of acceptance, the execute stage
// modifies the cell and writes it back when it passes the item on to the
// output register, and a forwarding register covers an item that reads the
// cell its predecessor is writing. The accepted item is registered in the
// execute stage first and its result then in the output register. While the
// output is stalled the block holds one item in the output register and one
// in the execute stage before in_stall rises. A pointer move out of the tape
// reports a fault and halts the block until reset; later items still get a
// result carrying their own address and no output byte.
`default_nettype none
module tape_machine_executor_core
  import tme_pkg::*;
#(
  parameter int TAPE_CELLS   = 4096,
  parameter int ADDRESS_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [15:0] amount,
  input  wire logic [15:0] current_address,
  input  wire logic [15:0] jump_target,
  input  wire logic [7:0]  input_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [15:0]      next_address,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic [15:0]      out_repeat,
  output logic [1:0]       fault
);

  localparam int PW = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;

  logic          accept;
  item_t         item;
  logic [PW-1:0] ptr;
  logic          clearing;
  logic [PW-1:0] clr_addr;
  logic          hold;
  wr_t           wr;
  logic [PW-1:0] wr_addr;
  logic [7:0]    rdata;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  // pointer, halt flag and clearing sweep
  tme_ctrl #(
    .TAPE_CELLS  (TAPE_CELLS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .amount         (amount),
    .current_address(current_address),
    .jump_target    (jump_target),
    .input_byte     (input_byte),
    .hold           (hold),
    .accept         (accept),
    .item           (item),
    .ptr            (ptr),
    .clearing       (clearing),
    .clr_addr       (clr_addr)
  );

  // the sweep owns the write port until it ends; no item is in flight then
  assign ram_we    = clearing || wr.en;
  assign ram_waddr = clearing ? clr_addr : wr_addr;
  assign ram_wdata = clearing ? 8'd0 : wr.data;

  tme_ram #(
    .WIDTH(8),
    .DEPTH(1 << PW)
  ) u_tape (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(ptr),
    .rdata(rdata)
  );

  tme_exec #(
    .PW(PW)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .addr_in     (ptr),
    .rdata       (rdata),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .hold        (hold),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .next_address(next_address),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_repeat  (out_repeat),
    .fault       (fault)
  );

endmodule
`default_nettype wire

>>> hdl/tme_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/tme_ctrl.sv
// Pointer stage: cell pointer, halt flag, post-reset clearing sweep, input accept.
// Depends on tme_pkg.
`default_nettype none
module tme_ctrl
  import tme_pkg::*;
#(
  parameter int TAPE_CELLS   = 4096,
  parameter int ADDRESS_BITS = 16,
  localparam int PW = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    mode,
  input  wire logic [15:0]   amount,
  input  wire logic [15:0]   current_address,
  input  wire logic [15:0]   jump_target,
  input  wire logic [7:0]    input_byte,
  input  wire logic          hold,
  output logic               accept,
  output item_t              item,
  output logic [PW-1:0]      ptr,
  output logic               clearing,
  output logic [PW-1:0]      clr_addr
);

  localparam int CW = ((PW > 16) ? PW : 16) + 1;
  localparam logic [15:0] ADDR_MASK =
    (ADDRESS_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << ADDRESS_BITS) - 64'd1);

  logic          halted;
  logic [PW-1:0] ptr_next;
  logic [CW-1:0] ptr_ext, amt_ext, sum;
  logic          under, over;
  mode_t         m;
  fault_t        flt;

  assign m       = mode_t'(mode);
  assign ptr_ext = CW'(ptr);
  assign amt_ext = CW'(amount);
  assign sum     = ptr_ext + amt_ext;
  assign under   = amt_ext > ptr_ext;
  assign over    = sum >= CW'(TAPE_CELLS);

  assign in_stall = clearing || hold;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    flt      = FAULT_NONE;
    ptr_next = ptr;
    if (!halted) begin
      case (m)
        MODE_LEFT: begin
          if (under) flt = FAULT_UNDER;
          else       ptr_next = PW'(ptr_ext - amt_ext);
        end
        MODE_RIGHT: begin
          if (over) flt = FAULT_OVER;
          else      ptr_next = PW'(sum);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    item.mode     = m;
    item.amount   = amount;
    item.cur      = current_address & ADDR_MASK;
    item.next_seq = (current_address + 16'd1) & ADDR_MASK;
    item.target   = jump_target & ADDR_MASK;
    item.data     = input_byte;
    item.active   = !halted && (flt == FAULT_NONE);
    item.fault    = flt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      halted   <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      // sweep the tape once, one cell a cycle
      if (clearing) begin
        clr_addr <= clr_addr + PW'(1);
        if (clr_addr == PW'(TAPE_CELLS - 1)) clearing <= 1'b0;
      end
      if (accept) begin
        ptr <= ptr_next;
        if (flt != FAULT_NONE) halted <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/tme_exec.sv
// Execute stage: cell read-modify-write with forwarding, and the output register.
// Depends on tme_pkg.
`default_nettype none
module tme_exec
  import tme_pkg::*;
#(
  parameter int PW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire item_t         item,
  input  wire logic [PW-1:0] addr_in,
  input  wire logic [7:0]    rdata,
  output wr_t                wr,
  output logic [PW-1:0]      wr_addr,
  output logic               hold,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [15:0]        next_address,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic [15:0]        out_repeat,
  output logic [1:0]         fault
);

  logic          s1_valid;
  item_t         s1;
  logic [PW-1:0] s1_addr;
  logic          fwd_valid;
  logic [PW-1:0] fwd_addr;
  logic [7:0]    fwd_data;
  logic          advance, take;
  logic [7:0]    cell_val;
  logic          amt_nz;
  logic [15:0]   nxt;
  logic          ov;
  logic [7:0]    ob;
  logic [15:0]   orep;

  assign advance = !result_valid || !result_stall;
  assign hold    = s1_valid && !advance;
  assign take    = s1_valid && advance;
  assign wr_addr = s1_addr;
  assign amt_nz  = s1.amount != 16'd0;

  // the memory misses a write made in the same cycle as its read
  assign cell_val = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;

  always_comb begin
    wr.en   = 1'b0;
    wr.data = cell_val;
    nxt     = s1.next_seq;
    ov      = 1'b0;
    ob      = 8'd0;
    orep    = 16'd0;
    if (!s1.active) begin
      nxt = s1.cur;
    end else begin
      case (s1.mode)
        MODE_ADD: begin
          wr.en   = take;
          wr.data = cell_val + s1.amount[7:0];
        end
        MODE_SUB: begin
          wr.en   = take;
          wr.data = cell_val - s1.amount[7:0];
        end
        MODE_READ: begin
          wr.en   = take && amt_nz;
          wr.data = s1.data;
        end
        MODE_WRITE: begin
          if (amt_nz) begin
            ov   = 1'b1;
            ob   = cell_val;
            orep = s1.amount;
          end
        end
        MODE_JZ:  if (cell_val == 8'd0) nxt = s1.target;
        MODE_JNZ: if (cell_val != 8'd0) nxt = s1.target;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      fwd_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // keep a waiting item, or load the one just accepted
      s1_valid <= accept || hold;
      if (wr.en)   fwd_valid <= 1'b1;
      if (take)                   result_valid <= 1'b1;
      else if (!result_stall)     result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1      <= item;
      s1_addr <= addr_in;
    end
    if (wr.en) begin
      fwd_addr <= s1_addr;
      fwd_data <= wr.data;
    end
    if (take) begin
      next_address <= nxt;
      out_valid    <= ov;
      out_byte     <= ob;
      out_repeat   <= orep;
      fault        <= s1.fault;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tme_checker.sv
// Port-level checks for tape_machine_executor_core, bound to the top level.
// Depends on tme_pkg.
`default_nettype none
module tme_checker
  import tme_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [15:0] next_address,
  input wire logic        out_valid,
  input wire logic [7:0]  out_byte,
  input wire logic [15:0] out_repeat,
  input wire logic [1:0]  fault
);

  logic seen_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_fault <= 1'b0;
    end else if (result_valid && !result_stall && fault != FAULT_NONE) begin
      seen_fault <= 1'b1;
    end
  end

  // a halted block reports no further fault
  a_single_fault: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen_fault |-> fault == FAULT_NONE)
    else $error("fault reported after halt");

  a_fault_no_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && fault != FAULT_NONE |-> !out_valid)
    else $error("byte emitted with a fault");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !out_valid |-> out_byte == 8'd0 && out_repeat == 16'd0)
    else $error("byte fields set without an emitted byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(next_address))
    else $error("stalled result changed");

endmodule

bind tape_machine_executor_core tme_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .next_address(next_address),
  .out_valid   (out_valid),
  .out_byte    (out_byte),
  .out_repeat  (out_repeat),
  .fault       (fault)
);
`default_nettype wire
